// File: rtl/adam3_pkg.sv
// ----------------------------------------------------------------------------
// adam3_pkg
// Shared types, codes, constants and a rounding helper for the three
// parameter Adam update block.
// ----------------------------------------------------------------------------
package adam3_pkg;

	localparam int MOMENT_WIDTH_DEF = 48;
	localparam int STALL_WIDTH_DEF  = 8;

	// shared unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	localparam logic [6:0] WORD_STEPS = 7'd64;
	localparam logic [6:0] SQRT_STEPS = 7'd32;

	// configuration register indexes
	localparam logic [2:0] REG_LR       = 3'd0;
	localparam logic [2:0] REG_BETA1    = 3'd1;
	localparam logic [2:0] REG_BETA2    = 3'd2;
	localparam logic [2:0] REG_EPS      = 3'd3;
	localparam logic [2:0] REG_PATIENCE = 3'd4;

	localparam logic [15:0] LR_RST       = 16'd655;
	localparam logic [31:0] BETA1_RST    = 32'd3865470566;
	localparam logic [31:0] BETA2_RST    = 32'd4290672329;
	localparam logic [15:0] EPS_RST      = 16'd43;
	localparam logic [7:0]  PATIENCE_RST = 8'd10;

	localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
	localparam logic [40:0] STEP_MAX = 41'h100_0000_0000;

	// gradient gains 0.1 and 0.05 in Q0.32
	localparam logic [28:0] GAIN_PROF  = 29'd429496730;
	localparam logic [28:0] GAIN_OTHER = 29'd214748365;

	localparam logic [19:0] PROF_MIN  = 20'd6554;
	localparam logic [19:0] PROF_MAX  = 20'd655360;
	localparam logic [16:0] TIGHT_MAX = 17'd65536;
	localparam logic [6:0]  CNT_MIN   = 7'd1;
	localparam logic [6:0]  CNT_MAX   = 7'd100;
	localparam logic [30:0] LOSS_DELTA = 31'd6;
	localparam logic [30:0] LOSS_FLOOR = 31'd656;

	typedef struct packed {
		logic        start;
		logic [1:0]  op;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
	} alu_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic        ovf;
		logic [63:0] hi;
		logic [63:0] lo;
	} alu_rsp_t;

	typedef struct packed {
		logic       improving;
		logic       converged;
		logic [7:0] stall_steps;
	} trk_t;

	// (hi:lo + 2^31) >> 32, saturated at lim
	function automatic logic [63:0] rnd_sat(input logic [63:0] hi, input logic [63:0] lo,
			input logic [63:0] lim);
		logic [64:0] nlo;
		logic [64:0] h;
		logic [63:0] r;
		nlo = {1'b0, lo} + 65'h0_8000_0000;
		h   = {1'b0, hi} + {64'd0, nlo[64]};
		r   = {h[31:0], nlo[63:32]};
		if (h[64:32] != 33'd0)
			return lim;
		else if (r > lim)
			return lim;
		else
			return r;
	endfunction

endpackage

// File: rtl/adam3_alu.sv
// ----------------------------------------------------------------------------
// adam3_alu
// Shared iterative unit: 64x64 shift-add multiply, 128/64 restoring divide
// and 64-bit integer square root, one bit (or one root bit) per cycle.
// ----------------------------------------------------------------------------
module adam3_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  adam3_pkg::alu_req_t req,
	output adam3_pkg::alu_rsp_t rsp
);

	logic        busy_q, done_q, ovf_q;
	logic [1:0]  op_q;
	logic [6:0]  cnt_q;
	logic [63:0] hi_q, lo_q, a_q, d_q;

	logic [64:0] msum;
	logic [64:0] dsh, ddif;
	logic        dge;
	logic [63:0] st;
	logic        sge;
	logic [63:0] dnz;

	assign msum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);
	assign dsh  = {hi_q, lo_q[63]};
	assign dge  = dsh >= {1'b0, d_q};
	assign ddif = dsh - {1'b0, d_q};
	assign st   = lo_q + a_q;
	assign sge  = hi_q >= st;
	// zero divisor counts as one LSB
	assign dnz  = (req.b == 64'd0) ? 64'd1 : req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= adam3_pkg::OP_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == adam3_pkg::OP_SQRT) ? adam3_pkg::SQRT_STEPS
				                                          : adam3_pkg::WORD_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			unique case (req.op)
				adam3_pkg::OP_DIV: begin
					hi_q  <= req.a;
					lo_q  <= req.c;
					d_q   <= dnz;
					ovf_q <= req.a >= dnz;
				end
				adam3_pkg::OP_SQRT: begin
					hi_q <= req.a;
					lo_q <= 64'd0;
					a_q  <= 64'h4000_0000_0000_0000;
				end
				default: begin
					hi_q <= 64'd0;
					lo_q <= req.b;
					a_q  <= req.a;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				adam3_pkg::OP_DIV: begin
					hi_q <= dge ? ddif[63:0] : dsh[63:0];
					lo_q <= {lo_q[62:0], dge};
				end
				adam3_pkg::OP_SQRT: begin
					if (sge) begin
						hi_q <= hi_q - st;
						lo_q <= (lo_q >> 1) + a_q;
					end else begin
						lo_q <= lo_q >> 1;
					end
					a_q <= a_q >> 2;
				end
				default: begin
					hi_q <= msum[64:1];
					lo_q <= {msum[0], lo_q[63:1]};
				end
			endcase
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.hi   = hi_q;
	assign rsp.lo   = lo_q;

endmodule

// File: rtl/adam3_track.sv
// ----------------------------------------------------------------------------
// adam3_track
// Loss improvement tracking, saturating stall count and convergence flag.
// ----------------------------------------------------------------------------
module adam3_track #(
	parameter int STALL_WIDTH = adam3_pkg::STALL_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic              clr,
	input  logic [30:0]       loss,
	input  logic [7:0]        patience,
	output adam3_pkg::trk_t   status
);

	logic [30:0]            last_q;
	logic [STALL_WIDTH-1:0] stall_q, stall_nxt;
	logic                   impr;
	logic [16:0]            stall_ext;
	adam3_pkg::trk_t        stat_q;

	assign impr = (last_q > loss) && ((last_q - loss) > adam3_pkg::LOSS_DELTA);

	always_comb begin
		stall_nxt = stall_q;
		if (impr)
			stall_nxt = '0;
		else if (stall_q != {STALL_WIDTH{1'b1}})
			stall_nxt = stall_q + 1'b1;
	end

	assign stall_ext = 17'(stall_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			stall_q <= '0;
			stat_q  <= '0;
		end else if (acc) begin
			if (clr) begin
				last_q  <= '0;
				stall_q <= '0;
				stat_q  <= '0;
			end else begin
				last_q                <= loss;
				stall_q               <= stall_nxt;
				stat_q.improving      <= impr;
				stat_q.converged      <= (stall_ext >= 17'(patience)) ||
				                         (loss < adam3_pkg::LOSS_FLOOR);
				stat_q.stall_steps    <= stall_ext[7:0];
			end
		end
	end

	assign status = stat_q;

endmodule

// File: rtl/adam_three_parameter_update.sv
// ----------------------------------------------------------------------------
// adam_three_parameter_update
// Adam update of profile, tightness and count with bias correction,
// clamping and loss stall tracking, sequenced over one shared unit.
// ----------------------------------------------------------------------------
// Sequence: a step transaction runs two power updates, then per parameter seven
//   multiplies, three divides, one root and a normalize loop. One transaction at
//   a time; the shared bit-serial multiply/divide/root unit sets the rate.
// Reset: async, active low; moments zero, beta powers 1.0, registers default.
// ----------------------------------------------------------------------------
module adam_three_parameter_update #(
	parameter int MOMENT_WIDTH = adam3_pkg::MOMENT_WIDTH_DEF,
	parameter int STALL_WIDTH  = adam3_pkg::STALL_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [30:0] recon_error,
	input  logic [30:0] total_loss,
	input  logic [19:0] profile_in,
	input  logic [16:0] tightness_in,
	input  logic [6:0]  count_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] profile_out,
	output logic [16:0] tightness_out,
	output logic [6:0]  count_out,
	output logic        improving,
	output logic        converged,
	output logic [7:0]  stall_steps
);

	localparam int          MAGW    = MOMENT_WIDTH - 1;
	localparam logic [63:0] MOM_MAX = (64'd1 << (MOMENT_WIDTH - 1)) - 64'd1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_POW1 = 4'd1;
	localparam logic [3:0] ST_POW2 = 4'd2;
	localparam logic [3:0] ST_GMAG = 4'd3;
	localparam logic [3:0] ST_MT1  = 4'd4;
	localparam logic [3:0] ST_MT2  = 4'd5;
	localparam logic [3:0] ST_G2   = 4'd6;
	localparam logic [3:0] ST_VT1  = 4'd7;
	localparam logic [3:0] ST_VT2  = 4'd8;
	localparam logic [3:0] ST_MHAT = 4'd9;
	localparam logic [3:0] ST_VHAT = 4'd10;
	localparam logic [3:0] ST_NORM = 4'd11;
	localparam logic [3:0] ST_SQRT = 4'd12;
	localparam logic [3:0] ST_LRMH = 4'd13;
	localparam logic [3:0] ST_STEP = 4'd14;
	localparam logic [3:0] ST_OUT  = 4'd15;

	logic [3:0]  state_q;
	logic        go_q;
	logic [1:0]  idx_q;

	logic [15:0] lr_q, eps_q;
	logic [31:0] b1_q, b2_q;
	logic [7:0]  pat_q;

	logic signed [MOMENT_WIDTH-1:0] m_q [3];
	logic [MAGW-1:0]                v_q [3];
	logic [32:0]                    pow1_q, pow2_q;

	logic [30:0] err_q;
	logic [19:0] prof_q;
	logic [16:0] tight_q;
	logic [6:0]  cnt_in_q;

	logic [43:0]        gmag_q;
	logic signed [63:0] t1_q;
	logic [MAGW-1:0]    g2_q, vt1_q, mh_q;
	logic [63:0]        nx_q;
	logic [4:0]         ns_q;
	logic [63:0]        den_q;

	logic [19:0] res_prof_q;
	logic [16:0] res_tight_q;
	logic [6:0]  res_cnt_q;

	logic        out_valid_q;
	logic [19:0] prof_out_q;
	logic [16:0] tight_out_q;
	logic [6:0]  cnt_out_q;
	adam3_pkg::trk_t stat_out_q;

	adam3_pkg::alu_req_t alu_req;
	adam3_pkg::alu_rsp_t alu_rsp;
	adam3_pkg::trk_t     trk;

	logic               acc;
	logic signed [MOMENT_WIDTH-1:0] m_cur;
	logic signed [63:0] m_ext;
	logic [63:0]        m_mag, v_cur;
	logic [32:0]        bc1, bc2, omb1, omb2;
	logic [63:0]        rnd_mom, rnd_one, div_mom;
	logic [59:0]        gsum;
	logic signed [64:0] msum;
	logic [63:0]        m_new;
	logic [64:0]        vsum;
	logic [63:0]        v_new;
	logic [63:0]        root;
	logic [40:0]        step_u;
	logic               step_neg;
	logic signed [42:0] step_s, prof_v, tight_v;
	logic [24:0]        cnt_r;
	logic signed [26:0] cnt_s, cnt_v;
	logic [41:0]        cnt_add;
	logic [19:0]        prof_new, prof_clr;
	logic [16:0]        tight_new, tight_clr;
	logic [6:0]         cnt_new, cnt_clr;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	assign m_cur = m_q[idx_q];
	assign m_ext = 64'(m_cur);
	assign m_mag = m_ext[63] ? 64'(-m_ext) : 64'(m_ext);
	assign v_cur = 64'(v_q[idx_q]);
	assign bc1   = adam3_pkg::ONE_Q32 - pow1_q;
	assign bc2   = adam3_pkg::ONE_Q32 - pow2_q;
	assign omb1  = adam3_pkg::ONE_Q32 - {1'b0, b1_q};
	assign omb2  = adam3_pkg::ONE_Q32 - {1'b0, b2_q};

	always_comb begin
		alu_req.start = go_q;
		alu_req.op    = adam3_pkg::OP_MUL;
		alu_req.a     = '0;
		alu_req.b     = '0;
		alu_req.c     = '0;
		unique case (state_q)
			ST_POW1: begin
				alu_req.a = 64'(pow1_q);
				alu_req.b = 64'(b1_q);
			end
			ST_POW2: begin
				alu_req.a = 64'(pow2_q);
				alu_req.b = 64'(b2_q);
			end
			ST_GMAG: begin
				alu_req.a = 64'(err_q);
				alu_req.b = (idx_q == 2'd0) ? 64'(adam3_pkg::GAIN_PROF)
				                            : 64'(adam3_pkg::GAIN_OTHER);
			end
			ST_MT1: begin
				alu_req.a = m_mag;
				alu_req.b = 64'(b1_q);
			end
			ST_MT2: begin
				alu_req.a = 64'(gmag_q);
				alu_req.b = 64'(omb1);
			end
			ST_G2: begin
				alu_req.a = 64'(gmag_q);
				alu_req.b = 64'(gmag_q);
			end
			ST_VT1: begin
				alu_req.a = v_cur;
				alu_req.b = 64'(b2_q);
			end
			ST_VT2: begin
				alu_req.a = 64'(g2_q);
				alu_req.b = 64'(omb2);
			end
			ST_MHAT: begin
				alu_req.op = adam3_pkg::OP_DIV;
				alu_req.a  = m_mag >> 32;
				alu_req.c  = m_mag << 32;
				alu_req.b  = 64'(bc1);
			end
			ST_VHAT: begin
				alu_req.op = adam3_pkg::OP_DIV;
				alu_req.a  = v_cur >> 32;
				alu_req.c  = v_cur << 32;
				alu_req.b  = 64'(bc2);
			end
			ST_SQRT: begin
				alu_req.op = adam3_pkg::OP_SQRT;
				alu_req.a  = nx_q;
			end
			ST_LRMH: begin
				alu_req.a = 64'(lr_q);
				alu_req.b = 64'(mh_q);
			end
			ST_STEP: begin
				alu_req.op = adam3_pkg::OP_DIV;
				alu_req.a  = alu_rsp.hi;
				alu_req.c  = alu_rsp.lo;
				alu_req.b  = den_q;
			end
			default: ;
		endcase
	end

	adam3_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	adam3_track #(
		.STALL_WIDTH (STALL_WIDTH)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.clr      (op),
		.loss     (total_loss),
		.patience (pat_q),
		.status   (trk)
	);

	// post processing of the shared unit result
	assign rnd_mom = adam3_pkg::rnd_sat(alu_rsp.hi, alu_rsp.lo, MOM_MAX);
	assign rnd_one = adam3_pkg::rnd_sat(alu_rsp.hi, alu_rsp.lo, 64'(adam3_pkg::ONE_Q32));
	assign div_mom = (alu_rsp.ovf || alu_rsp.lo > MOM_MAX) ? MOM_MAX : alu_rsp.lo;
	assign gsum    = alu_rsp.lo[59:0] + 60'd32768;

	assign msum = $signed({t1_q[63], t1_q}) - $signed({1'b0, rnd_mom});
	always_comb begin
		if (msum > $signed({1'b0, MOM_MAX}))
			m_new = MOM_MAX;
		else if (msum < -$signed({1'b0, MOM_MAX}))
			m_new = 64'(-MOM_MAX);
		else
			m_new = msum[63:0];
	end

	assign vsum  = {1'b0, 64'(vt1_q)} + {1'b0, rnd_mom};
	assign v_new = (vsum > {1'b0, MOM_MAX}) ? MOM_MAX : vsum[63:0];

	// undo the even pre-shift: half of it on the root
	assign root = alu_rsp.lo << (5'd16 - ns_q);

	assign step_u   = (alu_rsp.ovf || alu_rsp.lo > 64'(adam3_pkg::STEP_MAX))
	                  ? adam3_pkg::STEP_MAX : alu_rsp.lo[40:0];
	assign step_neg = m_cur[MOMENT_WIDTH-1];
	assign step_s   = step_neg ? -$signed({2'b0, step_u}) : $signed({2'b0, step_u});
	assign prof_v   = $signed(43'(prof_q)) - step_s;
	assign tight_v  = $signed(43'(tight_q)) - step_s;
	// count step rounds half away from zero
	assign cnt_add  = 42'(step_u) + 42'd32768;
	assign cnt_r    = cnt_add[40:16];
	assign cnt_s    = step_neg ? -$signed({2'b0, cnt_r}) : $signed({2'b0, cnt_r});
	assign cnt_v    = $signed(27'(cnt_in_q)) - cnt_s;

	always_comb begin
		if (prof_v < $signed(43'(adam3_pkg::PROF_MIN)))
			prof_new = adam3_pkg::PROF_MIN;
		else if (prof_v > $signed(43'(adam3_pkg::PROF_MAX)))
			prof_new = adam3_pkg::PROF_MAX;
		else
			prof_new = prof_v[19:0];

		if (tight_v < 43'sd0)
			tight_new = '0;
		else if (tight_v > $signed(43'(adam3_pkg::TIGHT_MAX)))
			tight_new = adam3_pkg::TIGHT_MAX;
		else
			tight_new = tight_v[16:0];

		if (cnt_v < $signed(27'(adam3_pkg::CNT_MIN)))
			cnt_new = adam3_pkg::CNT_MIN;
		else if (cnt_v > $signed(27'(adam3_pkg::CNT_MAX)))
			cnt_new = adam3_pkg::CNT_MAX;
		else
			cnt_new = cnt_v[6:0];

		if (profile_in < adam3_pkg::PROF_MIN)
			prof_clr = adam3_pkg::PROF_MIN;
		else if (profile_in > adam3_pkg::PROF_MAX)
			prof_clr = adam3_pkg::PROF_MAX;
		else
			prof_clr = profile_in;

		tight_clr = (tightness_in > adam3_pkg::TIGHT_MAX) ? adam3_pkg::TIGHT_MAX
		                                                  : tightness_in;

		if (count_in < adam3_pkg::CNT_MIN)
			cnt_clr = adam3_pkg::CNT_MIN;
		else if (count_in > adam3_pkg::CNT_MAX)
			cnt_clr = adam3_pkg::CNT_MAX;
		else
			cnt_clr = count_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			idx_q       <= '0;
			lr_q        <= adam3_pkg::LR_RST;
			b1_q        <= adam3_pkg::BETA1_RST;
			b2_q        <= adam3_pkg::BETA2_RST;
			eps_q       <= adam3_pkg::EPS_RST;
			pat_q       <= adam3_pkg::PATIENCE_RST;
			for (int i = 0; i < 3; i++) begin
				m_q[i] <= '0;
				v_q[i] <= '0;
			end
			pow1_q      <= adam3_pkg::ONE_Q32;
			pow2_q      <= adam3_pkg::ONE_Q32;
			err_q       <= '0;
			prof_q      <= '0;
			tight_q     <= '0;
			cnt_in_q    <= '0;
			gmag_q      <= '0;
			t1_q        <= '0;
			g2_q        <= '0;
			vt1_q       <= '0;
			mh_q        <= '0;
			nx_q        <= '0;
			ns_q        <= '0;
			den_q       <= '0;
			res_prof_q  <= '0;
			res_tight_q <= '0;
			res_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			prof_out_q  <= '0;
			tight_out_q <= '0;
			cnt_out_q   <= '0;
			stat_out_q  <= '0;
		end else begin
			go_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					adam3_pkg::REG_LR:       lr_q  <= cfg_data[15:0];
					adam3_pkg::REG_BETA1:    b1_q  <= cfg_data;
					adam3_pkg::REG_BETA2:    b2_q  <= cfg_data;
					adam3_pkg::REG_EPS:      eps_q <= cfg_data[15:0];
					adam3_pkg::REG_PATIENCE: pat_q <= cfg_data[7:0];
					default: ;
				endcase
			end

			// a finished transaction reloads the output register as it drains
			if (state_q == ST_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						err_q    <= recon_error;
						prof_q   <= profile_in;
						tight_q  <= tightness_in;
						cnt_in_q <= count_in;
						idx_q    <= '0;
						if (op) begin
							for (int i = 0; i < 3; i++) begin
								m_q[i] <= '0;
								v_q[i] <= '0;
							end
							pow1_q      <= adam3_pkg::ONE_Q32;
							pow2_q      <= adam3_pkg::ONE_Q32;
							res_prof_q  <= prof_clr;
							res_tight_q <= tight_clr;
							res_cnt_q   <= cnt_clr;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_POW1;
							go_q    <= 1'b1;
						end
					end
				end
				ST_POW1: begin
					if (alu_rsp.done) begin
						pow1_q  <= rnd_one[32:0];
						state_q <= ST_POW2;
						go_q    <= 1'b1;
					end
				end
				ST_POW2: begin
					if (alu_rsp.done) begin
						pow2_q  <= rnd_one[32:0];
						state_q <= ST_GMAG;
						go_q    <= 1'b1;
					end
				end
				ST_GMAG: begin
					if (alu_rsp.done) begin
						gmag_q  <= gsum[59:16];
						state_q <= ST_MT1;
						go_q    <= 1'b1;
					end
				end
				ST_MT1: begin
					if (alu_rsp.done) begin
						t1_q    <= m_ext[63] ? -$signed(rnd_mom) : $signed(rnd_mom);
						state_q <= ST_MT2;
						go_q    <= 1'b1;
					end
				end
				ST_MT2: begin
					if (alu_rsp.done) begin
						m_q[idx_q] <= MOMENT_WIDTH'(m_new);
						state_q    <= ST_G2;
						go_q       <= 1'b1;
					end
				end
				ST_G2: begin
					if (alu_rsp.done) begin
						g2_q    <= MAGW'(rnd_mom);
						state_q <= ST_VT1;
						go_q    <= 1'b1;
					end
				end
				ST_VT1: begin
					if (alu_rsp.done) begin
						vt1_q   <= MAGW'(rnd_mom);
						state_q <= ST_VT2;
						go_q    <= 1'b1;
					end
				end
				ST_VT2: begin
					if (alu_rsp.done) begin
						v_q[idx_q] <= MAGW'(v_new);
						state_q    <= ST_MHAT;
						go_q       <= 1'b1;
					end
				end
				ST_MHAT: begin
					if (alu_rsp.done) begin
						mh_q    <= MAGW'(div_mom);
						state_q <= ST_VHAT;
						go_q    <= 1'b1;
					end
				end
				ST_VHAT: begin
					if (alu_rsp.done) begin
						nx_q    <= div_mom;
						ns_q    <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					// largest even pre-shift, capped at 32, that keeps 64 bits
					if (ns_q != 5'd16 && nx_q[63:62] == 2'b00) begin
						nx_q <= nx_q << 2;
						ns_q <= ns_q + 5'd1;
					end else begin
						state_q <= ST_SQRT;
						go_q    <= 1'b1;
					end
				end
				ST_SQRT: begin
					if (alu_rsp.done) begin
						den_q   <= root + 64'(eps_q);
						state_q <= ST_LRMH;
						go_q    <= 1'b1;
					end
				end
				ST_LRMH: begin
					if (alu_rsp.done) begin
						state_q <= ST_STEP;
						go_q    <= 1'b1;
					end
				end
				ST_STEP: begin
					if (alu_rsp.done) begin
						unique case (idx_q)
							2'd0:    res_prof_q  <= prof_new;
							2'd1:    res_tight_q <= tight_new;
							default: res_cnt_q   <= cnt_new;
						endcase
						if (idx_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_GMAG;
							go_q    <= 1'b1;
						end
					end
				end
				default: begin
					if (!out_valid_q || out_ready) begin
						prof_out_q  <= res_prof_q;
						tight_out_q <= res_tight_q;
						cnt_out_q   <= res_cnt_q;
						stat_out_q  <= trk;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign profile_out   = prof_out_q;
	assign tightness_out = tight_out_q;
	assign count_out     = cnt_out_q;
	assign improving     = stat_out_q.improving;
	assign converged     = stat_out_q.converged;
	assign stall_steps   = stat_out_q.stall_steps;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q != ST_IDLE))
		else $error("accepted transaction did not start work");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> !alu_rsp.busy)
		else $error("shared unit started while busy");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && (!out_valid_q || out_ready)) |=> (out_valid_q && in_ready))
		else $error("result not presented after completion");

endmodule
